>>> hdl/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, character codes and helpers for the text to integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

    // default width of the internal character position counter
    localparam int POSITION_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX         = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNSIGNED_MODE = 1'b1;
    localparam int CFG_DATA_BITS = 6;

    // reset value of the radix register
    localparam logic [5:0] RADIX_RESET = 6'd10;

    // bases picked by automatic detection
    localparam logic [5:0] BASE_DEC = 6'd10;
    localparam logic [5:0] BASE_OCT = 6'd8;
    localparam logic [5:0] BASE_HEX = 6'd16;
    localparam logic [5:0] BASE_AUTO = 6'd0;

    // character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] UP_LETTER_OFS = CHAR_UP_A - 8'd10;
    localparam logic [7:0] LO_LETTER_OFS = CHAR_LO_A - 8'd10;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_NONE = 2'd0,
        STATUS_OK   = 2'd1,
        STATUS_OVF  = 2'd2
    } status_t;

    // input item
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [63:0] value;
        status_t     status;
        logic [15:0] consumed_count;
    } out_item_t;

    // decoded digit
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } digit_t;

    // digit value of a character, letters give 10 to 35
    function automatic digit_t digit_value(input logic [7:0] c);
        digit_t     d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            d.ok = 1'b1;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            diff = c - UP_LETTER_OFS;
            d.ok = 1'b1;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            diff = c - LO_LETTER_OFS;
            d.ok = 1'b1;
        end
        d.val = diff[5:0];
        return d;
    endfunction

    // saturation limit for the current sign and mode
    function automatic logic [63:0] limit_value(input logic umode, input logic neg);
        logic [63:0] lim;
        if (umode) begin
            lim = {64{1'b1}};
        end else if (neg) begin
            lim = {1'b1, 63'd0};
        end else begin
            lim = {1'b0, {63{1'b1}}};
        end
        return lim;
    endfunction

endpackage

`default_nettype wire

>>> hdl/text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming ASCII to integer parser with saturation on overflow.
// ----------------------------------------------------------------------------
// One character is taken per clock, back to back: each character goes through
// one 64 by 6 bit multiply-add and a limit compare straight into the parse
// state registers, so the input rate is one item per cycle. The character that
// carries last_char ends the string; its result is registered in an output
// register and the parser is rearmed at once for the next string. The input
// stalls only while a result waits in the output register and out_ready is low.
// Leading whitespace and one sign are skipped, radix 0 or 16 takes a 0x prefix,
// and radix 0 picks octal after a leading zero. The radix is sampled on the
// first character of each string; unsigned_mode is used as it stands.
`default_nettype none

module text_to_integer_parser #(
    parameter int POSITION_BITS = tti_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [tti_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tti_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // characters in
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire tti_pkg::in_item_t                   in_item,
    // results out
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output tti_pkg::out_item_t                       out_item
);

    import tti_pkg::*;

    localparam int CNT_BITS = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    typedef enum logic [5:0] {
        PH_SPACE  = 6'b000001,
        PH_FIRST  = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_PREFIX = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // configuration registers
    logic [5:0] radix_reg;
    logic       umode_reg;

    // parse state
    phase_t                   phase_reg, phase_next;
    logic                     neg_reg, neg_next;
    logic [63:0]              acc_reg, acc_next;
    status_t                  st_reg, st_next;
    logic [5:0]               base_reg, base_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] end_reg, end_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_acc_reg;
    logic        out_neg_reg;
    logic        out_umode_reg;
    status_t     out_st_reg;
    logic [15:0] out_cnt_reg;

    // per character working values
    logic                     accept;
    logic [7:0]               c;
    digit_t                   dg;
    logic                     is_ws;
    logic [5:0]               eb;
    logic [5:0]               scan_base;
    status_t                  scan_st;
    logic [70:0]              prod;
    logic                     scan_hit;
    logic                     scan_ovf;
    logic                     take_first;
    logic                     scan_now;
    phase_t                   ph1;
    logic                     neg1;
    logic [63:0]              acc1;
    status_t                  st1;
    logic [5:0]               base1;
    logic [POSITION_BITS-1:0] end1;
    logic [POSITION_BITS-1:0] pos1;
    logic [POSITION_BITS-1:0] end2;
    status_t                  st2;
    logic [CNT_BITS-1:0]      cnt_ext;
    logic [15:0]              cnt16;

    // handshake
    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            umode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RADIX:         radix_reg <= cfg_data;
                REG_UNSIGNED_MODE: umode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // character classes and the base in force for this character
    assign c     = in_item.char_in;
    assign dg    = digit_value(c);
    assign is_ws = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    assign eb    = (pos_reg == '0 && phase_reg == PH_SPACE) ? radix_reg : base_reg;

    // base used if this character is scanned as a digit
    always_comb
    begin
        case (phase_reg)
            PH_ZERO:             scan_base = (eb == BASE_AUTO) ? BASE_OCT : eb;
            PH_PREFIX, PH_DIGITS: scan_base = eb;
            default:             scan_base = (eb == BASE_AUTO) ? BASE_DEC : eb;
        endcase
    end

    // digit accumulate with overflow check against the limit
    assign scan_st  = (phase_reg == PH_ZERO) ? STATUS_OK : st_reg;
    assign prod     = 71'(acc_reg) * 71'(scan_base) + 71'(dg.val);
    assign scan_hit = dg.ok && (dg.val < scan_base);
    assign scan_ovf = (scan_st == STATUS_OVF) ||
                      (prod > 71'(limit_value(umode_reg, neg_reg)));

    // one character through the phase machine
    always_comb
    begin
        ph1        = phase_reg;
        neg1       = neg_reg;
        acc1       = acc_reg;
        st1        = st_reg;
        base1      = eb;
        end1       = end_reg;
        take_first = 1'b0;
        scan_now   = 1'b0;
        case (phase_reg)
            PH_SPACE:
            begin
                if (is_ws)
                begin
                    ph1 = PH_SPACE;
                end
                else if (c == CHAR_MINUS)
                begin
                    neg1 = 1'b1;
                    ph1  = PH_FIRST;
                end
                else if (c == CHAR_PLUS)
                begin
                    ph1 = PH_FIRST;
                end
                else
                begin
                    take_first = 1'b1;
                end
            end
            PH_FIRST:
            begin
                take_first = 1'b1;
            end
            PH_ZERO:
            begin
                if (c == CHAR_LO_X || c == CHAR_UP_X)
                begin
                    base1 = BASE_HEX;
                    ph1   = PH_PREFIX;
                end
                else
                begin
                    // the leading zero counts as a parsed digit
                    base1    = scan_base;
                    st1      = STATUS_OK;
                    scan_now = 1'b1;
                end
            end
            PH_PREFIX, PH_DIGITS:
            begin
                scan_now = 1'b1;
            end
            default:
            begin
                ph1 = phase_reg;
            end
        endcase

        // first significant character: a zero may open a prefix
        if (take_first)
        begin
            if ((eb == BASE_AUTO || eb == BASE_HEX) && c == CHAR_ZERO)
            begin
                ph1 = PH_ZERO;
            end
            else
            begin
                base1    = scan_base;
                scan_now = 1'b1;
            end
        end

        if (scan_now)
        begin
            ph1 = PH_DIGITS;
            if (!scan_hit)
            begin
                ph1  = PH_DONE;
                end1 = pos_reg;
            end
            else if (scan_ovf)
            begin
                st1 = STATUS_OVF;
            end
            else
            begin
                st1  = STATUS_OK;
                acc1 = prod[63:0];
            end
        end
    end

    // saturating position count
    assign pos1 = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    // end of string acts as a terminator that is never a digit
    assign end2 = (ph1 != PH_DONE) ? pos1 : end1;
    assign st2  = (ph1 == PH_ZERO) ? STATUS_OK : st1;

    // consumed count, saturated to 16 bits, zero when no digit was parsed
    assign cnt_ext = CNT_BITS'(end2);
    assign cnt16   = (st2 == STATUS_NONE) ? 16'd0 :
                     (cnt_ext > CNT_BITS'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];

    // next parse state: rearm after the last character
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        st_next    = st_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        if (accept)
        begin
            if (in_item.last_char)
            begin
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
                st_next    = STATUS_NONE;
                base_next  = radix_reg;
                pos_next   = '0;
                end_next   = '0;
            end
            else
            begin
                phase_next = ph1;
                neg_next   = neg1;
                acc_next   = acc1;
                st_next    = st1;
                base_next  = base1;
                pos_next   = pos1;
                end_next   = end1;
            end
        end
    end

    // output valid flag
    always_comb
    begin
        if (accept && in_item.last_char)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            st_reg        <= STATUS_NONE;
            base_reg      <= RADIX_RESET;
            pos_reg       <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            st_reg        <= st_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && in_item.last_char)
        begin
            out_acc_reg   <= acc1;
            out_neg_reg   <= neg1;
            out_umode_reg <= umode_reg;
            out_st_reg    <= st2;
            out_cnt_reg   <= cnt16;
        end
    end

    // final value: saturate on overflow, else apply the sign
    always_comb
    begin
        if (out_st_reg == STATUS_OVF)
        begin
            out_item.value = limit_value(out_umode_reg, out_neg_reg);
        end
        else if (out_neg_reg)
        begin
            out_item.value = 64'd0 - out_acc_reg;
        end
        else
        begin
            out_item.value = out_acc_reg;
        end
        out_item.status         = out_st_reg;
        out_item.consumed_count = out_cnt_reg;
    end

endmodule

`default_nettype wire
